FILE: hdl/sspid_pkg.sv
// Shared constants and types for the steering and speed control tick core.
`timescale 1ns / 1ps

package sspid_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_SPEED_KP     = 3'd0;
  localparam cfg_idx_t REG_SPEED_KI     = 3'd1;
  localparam cfg_idx_t REG_SPEED_KD     = 3'd2;
  localparam cfg_idx_t REG_STEER_KP     = 3'd3;
  localparam cfg_idx_t REG_STEER_KD     = 3'd4;
  localparam cfg_idx_t REG_DUTY_LIMIT   = 3'd5;
  localparam cfg_idx_t REG_SERVO_ENABLE = 3'd6;
  localparam cfg_idx_t REG_MOTOR_ENABLE = 3'd7;

  // Register reset values.
  localparam logic [15:0] SPEED_KP_RST = 16'd8192;
  localparam logic [15:0] SPEED_KI_RST = 16'd410;
  localparam logic [15:0] SPEED_KD_RST = 16'd0;
  localparam logic [15:0] STEER_KP_RST = 16'd410;
  localparam logic [15:0] STEER_KD_RST = 16'd205;
  localparam logic [16:0] DUTY_LIMIT_RST = 17'd65536;

  // Field widths fixed by the interface.
  localparam int DIST_W   = 16;
  localparam int STATUS_W = 8;
  localparam int DELTA_W  = 16;
  localparam int ANGLE_W  = 8;
  localparam int DUTY_W   = 17;
  localparam int TOTAL_W  = 48;

  localparam int DIST_BITS_DEF = 16;

  // Distance substituted for a missing or flagged reading, in mm.
  localparam int INVALID_DIST = 2000;

  // Steering angle, degrees; gains are Q4.12.
  localparam int GAIN_FRAC   = 12;
  localparam int ANGLE_BIAS  = 80;
  localparam int ANGLE_HOLD  = 90;
  localparam int ANGLE_MIN   = 40;
  localparam int ANGLE_MAX   = 135;

  // Speed target in 1/16 pulse units: full speed 100 at 800 mm and beyond,
  // falling by 150/800 per mm below that, i.e. 3 units of 1/16 per mm.
  localparam int SPEED_FULL_DIST = 800;
  localparam int SPEED_FULL_TGT  = 1600;

  // Speed error and PID widths.
  localparam int E_W  = 21;
  localparam int D1_W = E_W + 1;
  localparam int D2_W = E_W + 2;
  localparam int GAIN_W = 16;
  localparam int DU_W = 42;

  // Increment scaling: round(du / 500), ties away from zero.
  localparam int DU_DIV    = 500;
  localparam int DU_HALF   = DU_DIV / 2;
  // Any quotient of 2^20 or more drives the setting to a rail.
  localparam int Q_SAT     = 1 << 20;
  localparam longint Y_SAT = longint'(DU_DIV) * longint'(Q_SAT);
  localparam int Z_W       = 27;
  localparam int Q_W       = 21;
  // floor(z / 125) = (z * RECIP) >> RECIP_SH, exact for z below 2^27.
  localparam int RECIP_SH  = 34;
  localparam int RECIP_W   = 28;
  localparam logic [RECIP_W-1:0] RECIP = 28'd137438954;

  // Speed setting, Q3.16.
  localparam int SET_W   = 20;
  localparam int SET_MAX = (1 << (SET_W - 1)) - 1;
  localparam int SET_MIN = -(1 << (SET_W - 1));
  localparam int DUTY_FULL = 65536;

endpackage

FILE: hdl/steer_and_speed_pid_tick_core.sv
// Control tick core: PD steering and incremental PID speed loop, fully pipelined.
`timescale 1ns / 1ps

// One transaction in is one control tick and gives exactly one transaction out.
// The datapath is a register pipeline (input register, error formation,
// gain products, PID sum and steering angle, rounding prep, reciprocal divide by
// 500) ending in the result register, where the Q3.16 speed setting and the
// 48-bit pulse total are accumulated. A new tick is taken every clock cycle while
// the pipeline is not stalled. When the result register is full and stalled,
// the whole pipeline holds and in_stall rises in the same cycle. Configuration
// writes are always ready and take effect for ticks in flight as they reach
// the stages that use them; write them only while no tick is in flight.
module steer_and_speed_pid_tick_core #(
  parameter int DIST_BITS = sspid_pkg::DIST_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sspid_pkg::DELTA_W-1:0]  in_encoder_delta,
  input  logic [sspid_pkg::DIST_W-1:0]       in_left_dist,
  input  logic [sspid_pkg::STATUS_W-1:0]     in_left_status,
  input  logic [sspid_pkg::DIST_W-1:0]       in_right_dist,
  input  logic [sspid_pkg::STATUS_W-1:0]     in_right_status,
  input  logic [sspid_pkg::DIST_W-1:0]       in_front_dist,
  input  logic [sspid_pkg::STATUS_W-1:0]     in_front_status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sspid_pkg::ANGLE_W-1:0]      out_servo_angle,
  output logic [sspid_pkg::DUTY_W-1:0]       out_duty,
  output logic                               out_forward,
  output logic signed [sspid_pkg::DELTA_W-1:0]  out_last_delta,
  output logic signed [sspid_pkg::TOTAL_W-1:0]  out_total_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  sspid_pkg::cfg_idx_t                cfg_index,
  input  sspid_pkg::cfg_data_t               cfg_data
);
  import sspid_pkg::*;

  localparam int CLEAN_W = (DIST_BITS > 11) ? DIST_BITS : 11;
  localparam int ES_W    = CLEAN_W + 1;
  localparam int DES_W   = ES_W + 1;
  localparam int PTKP_W  = GAIN_W + 1 + ES_W;
  localparam int PTKD_W  = GAIN_W + 1 + DES_W;
  localparam int A_W     = PTKD_W + 2;
  localparam int PSKP_W  = GAIN_W + 1 + D1_W;
  localparam int PSKI_W  = GAIN_W + 1 + E_W;
  localparam int PSKD_W  = GAIN_W + 1 + D2_W;
  localparam int PROD_W  = Z_W + RECIP_W;
  localparam int SUM_W   = SET_W + 3;
  localparam int TGT_W   = 13;

  // ---------------------------------------------------------------- config
  logic [GAIN_W-1:0] speed_kp_r, speed_ki_r, speed_kd_r, steer_kp_r, steer_kd_r;
  logic [DUTY_W-1:0] duty_limit_r;
  logic              servo_enable_r, motor_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_kp_r     <= SPEED_KP_RST;
      speed_ki_r     <= SPEED_KI_RST;
      speed_kd_r     <= SPEED_KD_RST;
      steer_kp_r     <= STEER_KP_RST;
      steer_kd_r     <= STEER_KD_RST;
      duty_limit_r   <= DUTY_LIMIT_RST;
      servo_enable_r <= 1'b1;
      motor_enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED_KP:     speed_kp_r     <= cfg_data[GAIN_W-1:0];
        REG_SPEED_KI:     speed_ki_r     <= cfg_data[GAIN_W-1:0];
        REG_SPEED_KD:     speed_kd_r     <= cfg_data[GAIN_W-1:0];
        REG_STEER_KP:     steer_kp_r     <= cfg_data[GAIN_W-1:0];
        REG_STEER_KD:     steer_kd_r     <= cfg_data[GAIN_W-1:0];
        REG_DUTY_LIMIT:   duty_limit_r   <= cfg_data[DUTY_W-1:0];
        REG_SERVO_ENABLE: servo_enable_r <= cfg_data[0];
        REG_MOTOR_ENABLE: motor_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- pipeline control
  logic adv;
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  assign adv       = !(v6_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // ------------------------------------------------------- input register
  logic signed [DELTA_W-1:0] s0_delta_r;
  logic [DIST_W-1:0]         s0_left_r, s0_right_r, s0_front_r;
  logic [STATUS_W-1:0]       s0_lst_r, s0_rst_r, s0_fst_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_delta_r <= in_encoder_delta;
      s0_left_r  <= in_left_dist;
      s0_lst_r   <= in_left_status;
      s0_right_r <= in_right_dist;
      s0_rst_r   <= in_right_status;
      s0_front_r <= in_front_dist;
      s0_fst_r   <= in_front_status;
    end
  end

  // ------------------------------------------------- stage 1: error terms
  function automatic logic [CLEAN_W-1:0] clean_dist(input logic [DIST_W-1:0] d,
                                                    input logic [STATUS_W-1:0] st);
    logic [DIST_BITS-1:0] v;
    v = d[DIST_BITS-1:0];
    if (v == '0 || st != '0) begin
      clean_dist = CLEAN_W'(INVALID_DIST);
    end else begin
      clean_dist = CLEAN_W'(v);
    end
  endfunction

  logic [CLEAN_W-1:0]      left_c, right_c, front_c;
  logic [TGT_W-1:0]        f3;
  logic signed [TGT_W-1:0] tgt;
  logic signed [ES_W-1:0]  es_nxt;
  logic signed [DES_W-1:0] des_nxt;
  logic signed [E_W-1:0]   e_nxt;
  logic signed [D1_W-1:0]  d1_nxt;
  logic signed [D2_W-1:0]  d2_nxt;

  logic signed [ES_W-1:0]    steer_prev_r;
  logic signed [E_W-1:0]     e1_r, e2_r;
  logic signed [ES_W-1:0]    s1_es_r;
  logic signed [DES_W-1:0]   s1_des_r;
  logic signed [E_W-1:0]     s1_e_r;
  logic signed [D1_W-1:0]    s1_d1_r;
  logic signed [D2_W-1:0]    s1_d2_r;
  logic signed [DELTA_W-1:0] s1_delta_r;

  always_comb begin
    left_c  = clean_dist(s0_left_r, s0_lst_r);
    right_c = clean_dist(s0_right_r, s0_rst_r);
    front_c = clean_dist(s0_front_r, s0_fst_r);
    es_nxt  = $signed({1'b0, left_c}) - $signed({1'b0, right_c});
    des_nxt = DES_W'(es_nxt) - DES_W'(steer_prev_r);
    // Below the full-speed distance the front reading fits in ten bits.
    f3 = {3'b000, front_c[9:0]} + {2'b00, front_c[9:0], 1'b0};
    if (front_c >= CLEAN_W'(SPEED_FULL_DIST)) begin
      tgt = TGT_W'(SPEED_FULL_TGT);
    end else begin
      tgt = $signed(f3) - TGT_W'(SPEED_FULL_DIST);
    end
    e_nxt  = E_W'(tgt) - $signed({s0_delta_r[DELTA_W-1], s0_delta_r, 4'b0000});
    d1_nxt = D1_W'(e_nxt) - D1_W'(e1_r);
    d2_nxt = D2_W'(e_nxt) - (D2_W'(e1_r) <<< 1) + D2_W'(e2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_prev_r <= '0;
      e1_r         <= '0;
      e2_r         <= '0;
    end else if (adv && v0_r) begin
      steer_prev_r <= es_nxt;
      e1_r         <= e_nxt;
      e2_r         <= e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_es_r    <= es_nxt;
      s1_des_r   <= des_nxt;
      s1_e_r     <= e_nxt;
      s1_d1_r    <= d1_nxt;
      s1_d2_r    <= d2_nxt;
      s1_delta_r <= s0_delta_r;
    end
  end

  // --------------------------------------------- stage 2: gain products
  logic signed [PSKP_W-1:0]  s2_pkp_r;
  logic signed [PSKI_W-1:0]  s2_pki_r;
  logic signed [PSKD_W-1:0]  s2_pkd_r;
  logic signed [PTKP_W-1:0]  s2_tkp_r;
  logic signed [PTKD_W-1:0]  s2_tkd_r;
  logic signed [DELTA_W-1:0] s2_delta_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pkp_r   <= $signed({1'b0, speed_kp_r}) * s1_d1_r;
      s2_pki_r   <= $signed({1'b0, speed_ki_r}) * s1_e_r;
      s2_pkd_r   <= $signed({1'b0, speed_kd_r}) * s1_d2_r;
      s2_tkp_r   <= $signed({1'b0, steer_kp_r}) * s1_es_r;
      s2_tkd_r   <= $signed({1'b0, steer_kd_r}) * s1_des_r;
      s2_delta_r <= s1_delta_r;
    end
  end

  // ------------------------------------- stage 3: PID sum, steering angle
  logic signed [A_W-1:0]     a_sum;
  logic signed [DU_W-1:0]    du_nxt;
  logic [ANGLE_W-1:0]        angle_nxt;
  logic signed [DU_W-1:0]    s3_du_r;
  logic [ANGLE_W-1:0]        s3_angle_r;
  logic signed [DELTA_W-1:0] s3_delta_r;

  always_comb begin
    du_nxt = DU_W'(s2_pkp_r) + DU_W'(s2_pki_r) + DU_W'(s2_pkd_r);
    a_sum  = A_W'(s2_tkp_r) + A_W'(s2_tkd_r) + A_W'(ANGLE_BIAS << GAIN_FRAC);
    if (!servo_enable_r) begin
      angle_nxt = ANGLE_W'(ANGLE_HOLD);
    end else if (a_sum < A_W'(ANGLE_MIN << GAIN_FRAC)) begin
      angle_nxt = ANGLE_W'(ANGLE_MIN);
    end else if (a_sum >= A_W'((ANGLE_MAX + 1) << GAIN_FRAC)) begin
      angle_nxt = ANGLE_W'(ANGLE_MAX);
    end else begin
      angle_nxt = a_sum[GAIN_FRAC +: ANGLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_du_r    <= du_nxt;
      s3_angle_r <= angle_nxt;
      s3_delta_r <= s2_delta_r;
    end
  end

  // ---------------------------------------- stage 4: magnitude and rounding
  logic [DU_W-1:0]           du_mag;
  logic [DU_W-1:0]           y_val;
  logic                      s4_neg_r, s4_sat_r;
  logic [Z_W-1:0]            s4_z_r;
  logic [ANGLE_W-1:0]        s4_angle_r;
  logic signed [DELTA_W-1:0] s4_delta_r;

  always_comb begin
    du_mag = s3_du_r[DU_W-1] ? DU_W'(-s3_du_r) : DU_W'(s3_du_r);
    y_val  = du_mag + DU_W'(DU_HALF);
  end

  // Dividing by 500 is a shift by two and a reciprocal multiply for 125.
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_neg_r   <= s3_du_r[DU_W-1];
      s4_sat_r   <= (y_val >= DU_W'(Y_SAT));
      s4_z_r     <= y_val[Z_W+1:2];
      s4_angle_r <= s3_angle_r;
      s4_delta_r <= s3_delta_r;
    end
  end

  // ------------------------------------------ stage 5: reciprocal divide
  logic [PROD_W-1:0]         quot_prod;
  logic [Q_W-1:0]            q_mag;
  logic signed [Q_W:0]       q_nxt;
  logic signed [Q_W:0]       s5_q_r;
  logic [ANGLE_W-1:0]        s5_angle_r;
  logic signed [DELTA_W-1:0] s5_delta_r;

  always_comb begin
    quot_prod = PROD_W'(s4_z_r) * PROD_W'(RECIP);
    q_mag     = s4_sat_r ? Q_W'(Q_SAT) : quot_prod[RECIP_SH +: Q_W];
    q_nxt     = s4_neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_q_r     <= q_nxt;
      s5_angle_r <= s4_angle_r;
      s5_delta_r <= s4_delta_r;
    end
  end

  // ----------------------------- result register: setting, duty, pulse total
  logic signed [SET_W-1:0]   acc_r;
  logic signed [TOTAL_W-1:0] pulse_total_r;
  logic signed [SUM_W-1:0]   set_sum;
  logic signed [SET_W-1:0]   set_nxt;
  logic [SET_W-1:0]          set_mag;
  logic [DUTY_W-1:0]         duty_ceil;
  logic [DUTY_W-1:0]         duty_nxt;
  logic signed [TOTAL_W-1:0] total_nxt;

  logic [ANGLE_W-1:0]        s6_angle_r;
  logic [DUTY_W-1:0]         s6_duty_r;
  logic                      s6_forward_r;
  logic signed [DELTA_W-1:0] s6_delta_r;
  logic signed [TOTAL_W-1:0] s6_total_r;

  always_comb begin
    set_sum = SUM_W'(acc_r) + SUM_W'(s5_q_r);
    if (!motor_enable_r) begin
      set_nxt = '0;
    end else if (set_sum > SUM_W'(SET_MAX)) begin
      set_nxt = SET_W'(SET_MAX);
    end else if (set_sum < SUM_W'(SET_MIN)) begin
      set_nxt = SET_W'(SET_MIN);
    end else begin
      set_nxt = set_sum[SET_W-1:0];
    end
    set_mag   = set_nxt[SET_W-1] ? SET_W'(-set_nxt) : SET_W'(set_nxt);
    duty_ceil = (duty_limit_r > DUTY_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL) : duty_limit_r;
    // The magnitude is compared at full setting width; it only fits the duty when below the ceiling.
    duty_nxt  = (set_mag > SET_W'(duty_ceil)) ? duty_ceil : DUTY_W'(set_mag);
    total_nxt = pulse_total_r + TOTAL_W'(s5_delta_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      pulse_total_r <= '0;
    end else if (adv && v5_r) begin
      acc_r         <= set_nxt;
      pulse_total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_angle_r   <= s5_angle_r;
      s6_duty_r    <= duty_nxt;
      s6_forward_r <= (set_nxt > 0);
      s6_delta_r   <= s5_delta_r;
      s6_total_r   <= total_nxt;
    end
  end

  assign out_servo_angle = s6_angle_r;
  assign out_duty        = s6_duty_r;
  assign out_forward     = s6_forward_r;
  assign out_last_delta  = s6_delta_r;
  assign out_total_count = s6_total_r;

  // ------------------------------------------------------------ assertions
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_servo_angle >= ANGLE_W'(ANGLE_MIN) &&
                   out_servo_angle <= ANGLE_W'(ANGLE_MAX)))
    else $error("servo angle outside its clamp range");

  a_duty_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty <= DUTY_W'(DUTY_FULL) && out_duty <= duty_limit_r))
    else $error("duty above its ceiling");

  a_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !motor_enable_r) |-> (out_duty == '0 && !out_forward))
    else $error("motor disabled but duty or direction nonzero");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && v5_r) |=> ($stable(acc_r) && $stable(pulse_total_r)))
    else $error("accumulators changed without a transaction");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while the result register is blocked");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the steering and speed control tick core.
`timescale 1ns / 1ps

module testbench;
  import sspid_pkg::*;

  localparam int     LIMIT_CYCLES = 400000;
  localparam longint Q12          = 4096;
  localparam longint FALLBACK_MM  = 2000;
  localparam longint CRUISE_MM    = 800;
  localparam longint CRUISE_TGT   = 1600;
  localparam longint STEER_CENTER = 80;
  localparam longint STEER_HOLD   = 90;
  localparam longint STEER_LO     = 40;
  localparam longint STEER_HI     = 135;
  localparam longint INC_DIV      = 500;
  localparam longint SETTING_HI   = 524287;
  localparam longint SETTING_LO   = -524288;
  localparam longint FULL_DUTY    = 65536;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic [DIST_W-1:0]         left_dist;
    logic [STATUS_W-1:0]       left_status;
    logic [DIST_W-1:0]         right_dist;
    logic [STATUS_W-1:0]       right_status;
    logic [DIST_W-1:0]         front_dist;
    logic [STATUS_W-1:0]       front_status;
  } tick_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic [DUTY_W-1:0]         duty;
    logic                      forward;
    logic signed [DELTA_W-1:0] last_delta;
    logic signed [TOTAL_W-1:0] total;
  } tick_result_t;

  typedef struct packed {
    logic [15:0] speed_kp;
    logic [15:0] speed_ki;
    logic [15:0] speed_kd;
    logic [15:0] steer_kp;
    logic [15:0] steer_kd;
    logic [16:0] duty_limit;
    logic        servo_en;
    logic        motor_en;
  } gains_t;

  typedef struct packed {
    logic         typed;
    tick_t        stim;
    tick_result_t want;
  } table_row_t;

  localparam gains_t FACTORY = '{16'd8192, 16'd410, 16'd0, 16'd410, 16'd205,
                                 17'd65536, 1'b1, 1'b1};

  localparam int DIRECTED_ROWS = 16;
  localparam table_row_t DIRECTED [DIRECTED_ROWS] = '{
    // First tick after reset: every reading missing, so no steering error and full target.
    '{1'b1, '{16'sd0, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 8'd0},
      '{8'd80, 17'd27526, 1'b1, 16'sd0, 48'sd0}},
    // Largest left error and fastest forward count: servo and setting go to the rails.
    '{1'b1, '{16'sd32767, 16'd65535, 8'd0, 16'd1, 8'd0, 16'd800, 8'd0},
      '{8'd135, 17'd65536, 1'b0, 16'sd32767, 48'sd32767}},
    '{1'b1, '{16'h8000, 16'd1, 8'd0, 16'd65535, 8'd0, 16'd1, 8'd0},
      '{8'd40, 17'd65536, 1'b1, 16'h8000, 48'hFFFF_FFFF_FFFF}},
    '{1'b0, '{16'sd100, 16'd500, 8'd0, 16'd500, 8'd0, 16'd799, 8'd0}, '0},
    '{1'b0, '{16'sd100, 16'd300, 8'd0, 16'd700, 8'd0, 16'd800, 8'd0}, '0},
    '{1'b0, '{-16'sd1, 16'd0, 8'd0, 16'd1234, 8'd1, 16'd0, 8'd0}, '0},
    '{1'b0, '{16'sd0, 16'd1500, 8'h80, 16'd1500, 8'hFF, 16'd1500, 8'h55}, '0},
    '{1'b0, '{16'sd16, 16'd65535, 8'hAA, 16'd65535, 8'd0, 16'd65535, 8'd0}, '0},
    '{1'b0, '{16'sd200, 16'd2000, 8'd0, 16'd0, 8'd0, 16'd2000, 8'd0}, '0},
    '{1'b0, '{16'sd50, 16'd100, 8'd0, 16'd2100, 8'd0, 16'd400, 8'd0}, '0},
    '{1'b0, '{16'h8000, 16'd1, 8'd0, 16'd1, 8'd0, 16'd801, 8'd0}, '0},
    '{1'b0, '{16'sd1, 16'd40000, 8'd0, 16'd20, 8'd0, 16'd1, 8'd0}, '0},
    '{1'b0, '{16'sd100, 16'd800, 8'd0, 16'd820, 8'd0, 16'd900, 8'd0}, '0},
    '{1'b0, '{16'sd100, 16'd100, 8'd0, 16'd100, 8'd0, 16'd100, 8'hFF}, '0},
    '{1'b0, '{16'sd90, 16'd700, 8'd0, 16'd650, 8'd0, 16'd1200, 8'd0}, '0},
    '{1'b0, '{16'sd95, 16'd650, 8'd0, 16'd700, 8'd0, 16'd1200, 8'd0}, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [DELTA_W-1:0] in_encoder_delta;
  logic [DIST_W-1:0]         in_left_dist;
  logic [STATUS_W-1:0]       in_left_status;
  logic [DIST_W-1:0]         in_right_dist;
  logic [STATUS_W-1:0]       in_right_status;
  logic [DIST_W-1:0]         in_front_dist;
  logic [STATUS_W-1:0]       in_front_status;
  logic out_valid;
  logic out_stall;
  logic [ANGLE_W-1:0]        out_servo_angle;
  logic [DUTY_W-1:0]         out_duty;
  logic                      out_forward;
  logic signed [DELTA_W-1:0] out_last_delta;
  logic signed [TOTAL_W-1:0] out_total_count;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  // Controller model state and its register copy.
  gains_t             gains;
  logic signed [17:0] steer_err_q;
  logic signed [23:0] speed_err_q;
  logic signed [23:0] speed_err_qq;
  logic signed [19:0] speed_set_q;
  logic [47:0]        pulse_sum_q;

  tick_result_t awaited_results [$];
  int  errors = 0;
  int  cycle_count = 0;
  bit  sender_calm = 1'b0;
  bit  flood = 1'b0;
  bit  long_hold_req = 1'b0;

  steer_and_speed_pid_tick_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_encoder_delta (in_encoder_delta),
    .in_left_dist     (in_left_dist),
    .in_left_status   (in_left_status),
    .in_right_dist    (in_right_dist),
    .in_right_status  (in_right_status),
    .in_front_dist    (in_front_dist),
    .in_front_status  (in_front_status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_servo_angle  (out_servo_angle),
    .out_duty         (out_duty),
    .out_forward      (out_forward),
    .out_last_delta   (out_last_delta),
    .out_total_count  (out_total_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint usable_mm(input logic [15:0] mm, input logic [7:0] status);
    return (mm == 16'd0 || status != 8'd0) ? FALLBACK_MM : longint'(mm);
  endfunction

  // Runs one control tick on the model state and returns the outputs it should give.
  function automatic tick_result_t advance_controller(input tick_t t);
    longint lm, rm, fm, es, acc, ang, tgt, err, e1, e2, du, step, s, mag, lim;
    tick_result_t r;
    lm = usable_mm(t.left_dist, t.left_status);
    rm = usable_mm(t.right_dist, t.right_status);
    fm = usable_mm(t.front_dist, t.front_status);

    es = lm - rm;
    acc = STEER_CENTER * Q12 + longint'(gains.steer_kp) * es
        + longint'(gains.steer_kd) * (es - longint'(steer_err_q));
    steer_err_q = 18'(es);
    if (!gains.servo_en) begin
      ang = STEER_HOLD;
    end else if (acc < STEER_LO * Q12) begin
      ang = STEER_LO;
    end else begin
      ang = acc / Q12;
      if (ang > STEER_HI) ang = STEER_HI;
    end

    // Errors are kept in sixteenths of a pulse, so 3 per mm is 150/800 of a pulse per mm.
    tgt = (fm >= CRUISE_MM) ? CRUISE_TGT : CRUISE_TGT - 3 * (CRUISE_MM - fm);
    err = tgt - 16 * longint'(t.delta);
    e1 = longint'(speed_err_q);
    e2 = longint'(speed_err_qq);
    du = longint'(gains.speed_kp) * (err - e1) + longint'(gains.speed_ki) * err
       + longint'(gains.speed_kd) * (err - 2 * e1 + e2);
    speed_err_qq = speed_err_q;
    speed_err_q = 24'(err);

    // The increment divides by 500 and rounds half away from zero.
    step = (du >= 0) ? (du + INC_DIV / 2) / INC_DIV : -((INC_DIV / 2 - du) / INC_DIV);
    s = longint'(speed_set_q) + step;
    if (s > SETTING_HI) s = SETTING_HI;
    if (s < SETTING_LO) s = SETTING_LO;
    if (!gains.motor_en) s = 0;
    speed_set_q = 20'(s);

    mag = (s > 0) ? s : -s;
    lim = (gains.duty_limit > 17'(FULL_DUTY)) ? FULL_DUTY : longint'(gains.duty_limit);
    if (mag > lim) mag = lim;
    pulse_sum_q = pulse_sum_q + 48'(longint'(t.delta));

    r.angle = 8'(ang);
    r.duty = 17'(mag);
    r.forward = (s > 0);
    r.last_delta = t.delta;
    r.total = pulse_sum_q;
    return r;
  endfunction

  // Mostly plausible driving ticks, with some fully random noise mixed in.
  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(0, 9) < 7) begin
      t.delta = 16'(int'($urandom_range(0, 220)) - 60);
      t.left_dist = 16'($urandom_range(1, 2500));
      t.right_dist = 16'($urandom_range(1, 2500));
      t.front_dist = 16'($urandom_range(1, 1600));
      t.left_status = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
      t.right_status = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
      t.front_status = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
      if ($urandom_range(0, 19) == 0) t.front_dist = 16'd0;
    end else begin
      t = 88'({$urandom, $urandom, $urandom});
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input bit typed, input tick_result_t typed_want);
    int gap;
    tick_result_t got;
    if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
    gap = (sender_calm || flood) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_encoder_delta <= t.delta;
    in_left_dist <= t.left_dist;
    in_left_status <= t.left_status;
    in_right_dist <= t.right_dist;
    in_right_status <= t.right_status;
    in_front_dist <= t.front_dist;
    in_front_status <= t.front_status;
    do @(posedge clk); while (in_stall);
    got = advance_controller(t);
    awaited_results.push_back(typed ? typed_want : got);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input gains_t g);
    cfg_data_t vals [8];
    vals[REG_SPEED_KP] = cfg_data_t'(g.speed_kp);
    vals[REG_SPEED_KI] = cfg_data_t'(g.speed_ki);
    vals[REG_SPEED_KD] = cfg_data_t'(g.speed_kd);
    vals[REG_STEER_KP] = cfg_data_t'(g.steer_kp);
    vals[REG_STEER_KD] = cfg_data_t'(g.steer_kd);
    vals[REG_DUTY_LIMIT] = g.duty_limit;
    vals[REG_SERVO_ENABLE] = cfg_data_t'(g.servo_en);
    vals[REG_MOTOR_ENABLE] = cfg_data_t'(g.motor_en);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    gains = g;
  endtask

  // Result side: a random stall before each transaction, and one long hold on request.
  initial begin
    int hold;
    bit calm;
    out_stall = 1'b0;
    calm = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 13);
      if (long_hold_req) begin
        hold = 48;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with no tick outstanding");
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_servo_angle !== want.angle) begin
          $error("servo_angle: expected %0d, got %0d", want.angle, out_servo_angle);
          errors++;
        end
        if (out_duty !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, out_duty);
          errors++;
        end
        if (out_forward !== want.forward) begin
          $error("forward: expected %0d, got %0d", want.forward, out_forward);
          errors++;
        end
        if (out_last_delta !== want.last_delta) begin
          $error("last_delta: expected %0d, got %0d", want.last_delta, out_last_delta);
          errors++;
        end
        if (out_total_count !== want.total) begin
          $error("total_count: expected %0d, got %0d", want.total, out_total_count);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tick_result_t none;
    gains_t g;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_encoder_delta = '0;
    in_left_dist = '0;
    in_left_status = '0;
    in_right_dist = '0;
    in_right_status = '0;
    in_front_dist = '0;
    in_front_status = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gains = FACTORY;
    steer_err_q = '0;
    speed_err_q = '0;
    speed_err_qq = '0;
    speed_set_q = '0;
    pulse_sum_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_tick(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
    wait_drained();

    // Hold the result side while ticks keep streaming, so the pipeline backs up.
    long_hold_req = 1'b1;
    flood = 1'b1;
    repeat (24) send_tick(random_tick(), 1'b0, none);
    flood = 1'b0;

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd65536, 1'b1, 1'b1};
        1: g = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 17'd0, 1'b0, 1'b1};
        // Only the integral term at 250 makes every odd error land on a rounding tie.
        2: g = '{16'd0, 16'd250, 16'd0, 16'd4096, 16'd0, 17'h1FFFF, 1'b1, 1'b1};
        3: g = '{16'd8192, 16'd410, 16'd0, 16'd410, 16'd205, 17'd65536, 1'b1, 1'b0};
        4: g = '{16'd1024, 16'd64, 16'd512, 16'd100, 16'd4000, 17'd30000, 1'b1, 1'b1};
        default: begin
          g.speed_kp = 16'($urandom);
          g.speed_ki = 16'($urandom);
          g.speed_kd = 16'($urandom);
          g.steer_kp = 16'($urandom);
          g.steer_kd = 16'($urandom);
          g.duty_limit = 17'($urandom_range(0, 131071));
          g.servo_en = ($urandom_range(0, 3) != 0);
          g.motor_en = ($urandom_range(0, 3) != 0);
        end
      endcase
      load_settings(g);
      for (int k = 0; k < 85; k++) begin
        if (p == 4 && k == 40) wait_drained();
        send_tick(random_tick(), 1'b0, none);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
